>>> hw/rtl/ffd_pkg.sv
package ffd_pkg;

  localparam int FRAME_CAPACITY = 64;
  localparam int IDX_W = $clog2(FRAME_CAPACITY);
  localparam int LEN_W = $clog2(FRAME_CAPACITY + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] END_BYTE_RST = 8'hFF;
  localparam logic [2:0] END_REPEAT_RST = 3'd3;
  localparam logic [2:0] RUN_MAX = 3'd7;

  localparam logic CFG_END_BYTE = 1'b0;
  localparam logic CFG_END_REPEAT = 1'b1;

  typedef enum logic [1:0] {
    K_STORED   = 2'd0,
    K_DISCARD  = 2'd1,
    K_OVERFLOW = 2'd2,
    K_FRAME    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  len;
    logic [31:0]       rx_count;
    logic [31:0]       frames_done;
    logic [31:0]       drops_done;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic frame_done;
  } back_stat_t;

endpackage

>>> hw/rtl/ffd_if.sv
interface ffd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  frame_byte;
  logic [5:0]  byte_index;
  logic [6:0]  frame_length;
  logic        last;
  logic [31:0] rx_count;
  logic [31:0] frames_done;
  logic [31:0] drops_done;

  modport source (output valid, output kind, output frame_byte, output byte_index,
                  output frame_length, output last, output rx_count,
                  output frames_done, output drops_done, input ready);
  modport sink (input valid, input kind, input frame_byte, input byte_index,
                input frame_length, input last, input rx_count,
                input frames_done, input drops_done, output ready);
endinterface

>>> hw/rtl/ffd_front.sv
module ffd_front import ffd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ffd_in_if.sink     in_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd,
  output mem_wr_t    mem_wr,
  input  back_stat_t stat
);

  localparam logic [LEN_W-1:0] FILL_FULL = LEN_W'(FRAME_CAPACITY);

  logic [7:0]       end_byte_r;
  logic [2:0]       end_repeat_r;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [2:0]       run_r, run_nxt;
  logic             dropping_r, dropping_nxt;
  logic             busy_r, busy_nxt;
  logic [31:0]      rx_r, rx_nxt;
  logic [31:0]      frm_r, frm_nxt;
  logic [31:0]      drp_r, drp_nxt;

  logic             accept;
  logic             is_end;
  logic [2:0]       target;
  logic [2:0]       run_inc;
  logic [LEN_W-1:0] fill_inc;

  assign in_ch.ready = !busy_r && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_end      = (in_ch.rx_byte == end_byte_r);
  assign target      = (end_repeat_r == 3'd0) ? 3'd1 : end_repeat_r;
  assign run_inc     = !is_end ? 3'd0 : ((run_r == RUN_MAX) ? RUN_MAX : run_r + 3'd1);
  assign fill_inc    = fill_r + LEN_W'(1);

  always_comb begin
    fill_nxt     = fill_r;
    run_nxt      = run_r;
    dropping_nxt = dropping_r;
    busy_nxt     = busy_r && !stat.frame_done;
    rx_nxt       = rx_r;
    frm_nxt      = frm_r;
    drp_nxt      = drp_r;
    q_cmd.kind   = K_STORED;
    q_cmd.len    = fill_r;
    mem_wr.en    = 1'b0;
    mem_wr.addr  = fill_r[IDX_W-1:0];
    mem_wr.data  = in_ch.rx_byte;
    if (accept) begin
      rx_nxt = rx_r + 32'd1;
      if (dropping_r) begin
        q_cmd.kind = K_DISCARD;
        if (run_inc >= target) begin
          run_nxt      = 3'd0;
          dropping_nxt = 1'b0;
        end else begin
          run_nxt = run_inc;
        end
      end else if (fill_r == FILL_FULL) begin
        q_cmd.kind = K_OVERFLOW;
        q_cmd.len  = '0;
        fill_nxt   = '0;
        drp_nxt    = drp_r + 32'd1;
        if (is_end && target == 3'd1) begin
          run_nxt      = 3'd0;
          dropping_nxt = 1'b0;
        end else begin
          run_nxt      = is_end ? 3'd1 : 3'd0;
          dropping_nxt = 1'b1;
        end
      end else begin
        mem_wr.en = 1'b1;
        q_cmd.len = fill_inc;
        if (is_end && run_inc >= target) begin
          q_cmd.kind = K_FRAME;
          frm_nxt    = frm_r + 32'd1;
          fill_nxt   = '0;
          run_nxt    = 3'd0;
          busy_nxt   = 1'b1;
        end else begin
          fill_nxt = fill_inc;
          run_nxt  = run_inc;
        end
      end
    end
    q_cmd.rx_count    = rx_nxt;
    q_cmd.frames_done = frm_nxt;
    q_cmd.drops_done  = drp_nxt;
  end

  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_byte_r   <= END_BYTE_RST;
      end_repeat_r <= END_REPEAT_RST;
      fill_r       <= '0;
      run_r        <= '0;
      dropping_r   <= 1'b0;
      busy_r       <= 1'b0;
      rx_r         <= '0;
      frm_r        <= '0;
      drp_r        <= '0;
    end else begin
      fill_r     <= fill_nxt;
      run_r      <= run_nxt;
      dropping_r <= dropping_nxt;
      busy_r     <= busy_nxt;
      rx_r       <= rx_nxt;
      frm_r      <= frm_nxt;
      drp_r      <= drp_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_END_BYTE:   end_byte_r <= cfg_data;
          CFG_END_REPEAT: end_repeat_r <= cfg_data[2:0];
          default:        end_byte_r <= end_byte_r;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !accept) else $error("byte accepted during frame emission");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL) else $error("fill level beyond capacity");
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    dropping_r |-> fill_r == '0) else $error("frame store not empty while dropping");
`endif

endmodule

>>> hw/rtl/ffd_queue.sv
module ffd_queue import ffd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("command queue overrun");
`endif

endmodule

>>> hw/rtl/ffd_back.sv
module ffd_back import ffd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  input  mem_wr_t    mem_wr,
  output back_stat_t stat,
  ffd_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_SEND = 3'b100
  } bstate_t;

  bstate_t          st_r, st_nxt;
  cmd_t             cur_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       store_r [FRAME_CAPACITY];
  logic [7:0]       rd_data_r;

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_byte_r;
  logic [5:0]       out_idx_r;
  logic [6:0]       out_len_r;
  logic             out_last_r;
  logic [31:0]      out_rx_r, out_frm_r, out_drp_r;

  logic             out_free;
  logic             is_last;
  logic             load_status;
  logic             load_byte;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign is_last     = ({1'b0, idx_r} + LEN_W'(1)) == cur_r.len;
  assign load_status = (st_r == B_IDLE) && q_valid && (q_cmd.kind != K_FRAME) && out_free;
  assign load_byte   = (st_r == B_SEND) && out_free;
  assign q_pop       = (st_r == B_IDLE) && q_valid && ((q_cmd.kind == K_FRAME) || out_free);
  assign stat.frame_done = load_byte && is_last;

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    case (st_r)
      B_IDLE: begin
        if (q_valid && q_cmd.kind == K_FRAME) begin
          st_nxt  = B_READ;
          idx_nxt = '0;
        end
      end
      B_READ: st_nxt = B_SEND;
      B_SEND: begin
        if (out_free) begin
          if (is_last) begin
            st_nxt = B_IDLE;
          end else begin
            st_nxt  = B_READ;
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      store_r[mem_wr.addr] <= mem_wr.data;
    end
    rd_data_r <= store_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    idx_r <= idx_nxt;
    if (load_status) begin
      out_kind_r <= q_cmd.kind;
      out_byte_r <= '0;
      out_idx_r  <= '0;
      out_len_r  <= q_cmd.len;
      out_last_r <= 1'b1;
      out_rx_r   <= q_cmd.rx_count;
      out_frm_r  <= q_cmd.frames_done;
      out_drp_r  <= q_cmd.drops_done;
    end else if (load_byte) begin
      out_kind_r <= K_FRAME;
      out_byte_r <= rd_data_r;
      out_idx_r  <= idx_r;
      out_len_r  <= cur_r.len;
      out_last_r <= is_last;
      out_rx_r   <= cur_r.rx_count;
      out_frm_r  <= cur_r.frames_done;
      out_drp_r  <= cur_r.drops_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_status || load_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.frame_byte   = out_byte_r;
  assign out_ch.byte_index   = out_idx_r;
  assign out_ch.frame_length = out_len_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.rx_count     = out_rx_r;
  assign out_ch.frames_done  = out_frm_r;
  assign out_ch.drops_done   = out_drp_r;

`ifndef SYNTHESIS
  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != B_IDLE |-> {1'b0, idx_r} < cur_r.len)
    else $error("emission index outside frame");
`endif

endmodule

>>> hw/rtl/triple_ff_frame_deframer.sv
// terminator-delimited frame deframer
// in_ch carries one received byte per transaction (valid/ready). every byte
// gives one status result on out_ch, except the byte that completes a
// terminator run (end_repeat copies of end_byte, reset 3 x 0xff): that byte
// releases the whole stored frame, one result per stored byte with index,
// frame length and last set on the final byte.
// cfg_we/cfg_index/cfg_data write end_byte (index 0) or end_repeat (index 1);
// write only while the block is idle.
// a status result is registered in the command queue and then in the output
// register; each byte of a released frame is also read from the frame store.
// throughput: one byte per cycle while only status results are produced and
// out_ch ready stays high, with a 2-entry command queue; a completed frame is
// read back from the frame store byte by byte (read, then send), and
// in_ch ready stays low until its last byte has been loaded for output.
// reset (rst_n low, synchronous) sets the frame store fill level to zero, clears the
// counters and restores end_byte and end_repeat to their defaults.
// when the receiver stalls, the output register holds its result, the queue
// fills and in_ch ready drops; nothing is lost.
module triple_ff_frame_deframer import ffd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ffd_in_if.sink     in_ch,
  ffd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  mem_wr_t    mem_wr;
  back_stat_t stat;

  ffd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .mem_wr    (mem_wr),
    .stat      (stat)
  );

  ffd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  ffd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .mem_wr  (mem_wr),
    .stat    (stat),
    .out_ch  (out_ch)
  );

endmodule
